FILE: rtl/lns_pkg.sv
// Shared types, widths and constants of the Laplace noise sampler.
// Holds the pipeline item struct, the result struct and the log2 constant function.
// Depends on nothing; every other file imports it.
package lns_pkg;

	localparam int UNIFORM_BITS = 16;
	localparam int RAW_W        = 16;
	localparam int OUT_W        = 21;
	localparam int SCALE_W      = 16;
	localparam int FRAC_W       = 16;
	localparam int MANT_W       = 32;
	localparam int SHIFT_W      = $clog2(MANT_W);
	localparam int K_W          = $clog2(UNIFORM_BITS);
	localparam int LOG_W        = K_W + FRAC_W;
	localparam int SQ_STAGES    = FRAC_W;

	localparam logic [MANT_W-1:0]  LN2_Q32     = 32'd2977044472;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam logic [OUT_W-1:0]   POS_LIMIT   = 21'h0FFFFF;
	localparam logic [OUT_W-1:0]   NEG_LIMIT   = 21'h100000;

	typedef struct packed {
		logic              positive;
		logic              zero;
		logic [K_W-1:0]    k;
		logic [FRAC_W-1:0] frac;
		logic [MANT_W-1:0] mant;
	} lns_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] sample;
		logic             sat;
	} lns_res_t;

	function automatic logic [LOG_W-1:0] log2_const(input longint unsigned x);
		longint unsigned   m;
		logic [K_W-1:0]    k;
		logic [FRAC_W-1:0] frac;
		k = '0;
		frac = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) begin
				k = K_W'(i);
			end
		end
		m = x << (31 - int'(k));
		for (int i = 0; i < FRAC_W; i++) begin
			m = (m * m) >> 31;
			frac = {frac[FRAC_W-2:0], (m >= 64'h1_0000_0000)};
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
			end
		end
		return {k, frac};
	endfunction

	localparam logic [LOG_W-1:0] LOG2_MAX =
		log2_const((64'd1 << UNIFORM_BITS) - 64'd1);

endpackage

FILE: rtl/lns_sqr_stage.sv
// One squaring step of the fixed-point log2: squares the Q31 mantissa and
// yields the next fraction bit, with one register stage at the output.
// Depends on lns_pkg for the item struct and widths.
module lns_sqr_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              prev_valid,
	input  lns_pkg::lns_item_t prev_item,
	output logic              next_valid,
	output lns_pkg::lns_item_t next_item
);
	import lns_pkg::*;

	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]     sh;
	lns_item_t           item_c;
	logic                valid_s1;
	lns_item_t           item_s1;

	always_comb begin
		sq = (2*MANT_W)'(prev_item.mant) * (2*MANT_W)'(prev_item.mant);
		sh = sq[2*MANT_W-1:MANT_W-1];
		item_c = prev_item;
		item_c.frac = {prev_item.frac[FRAC_W-2:0], sh[MANT_W]};
		item_c.mant = sh[MANT_W] ? sh[MANT_W:1] : sh[MANT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_c;
		end
	end

	assign next_valid = valid_s1;
	assign next_item  = item_s1;

	// A nonzero log argument keeps its mantissa normalized to [1,2).
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_s1.zero |-> item_s1.mant[MANT_W-1])
		else $error("mantissa lost its leading one");

endmodule

FILE: rtl/laplace_noise_sampler_unit.sv
// Laplace noise sampler: maps one uniform word to one Laplace sample by inverse CDF.
// Depends on lns_pkg and on lns_sqr_stage for the log2 squaring pipeline.
//
// Usage:
// The input channel (uniform_valid, uniform_ready, uniform_raw) takes one raw
// uniform word per transfer. The output channel (noise_valid, noise_ready,
// noise_sample, saturated) gives one signed sample with 8 fraction bits per input.
// The configuration channel (cfg_valid, cfg_ready, noise_scale) writes the scale
// register and is always ready; write it only while no sample is in flight.
// Throughput is one sample per cycle unless the output stalls; the depth is
// set by the sixteen squaring stages of the log2 mantissa, one 32 by 32
// multiplier each.
// An output register plus a skid register part the two sides: when noise_ready
// is low, one more result is caught in the skid register, then uniform_ready
// drops and the whole pipeline holds until the receiver takes a transfer.
// Reset clears all valid bits and sets the scale register to 1.0 (256).
module laplace_noise_sampler_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      uniform_valid,
	output logic                      uniform_ready,
	input  logic [lns_pkg::RAW_W-1:0] uniform_raw,
	output logic                      noise_valid,
	input  logic                      noise_ready,
	output logic signed [lns_pkg::OUT_W-1:0] noise_sample,
	output logic                      saturated,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lns_pkg::SCALE_W-1:0] noise_scale
);
	import lns_pkg::*;

	logic [SCALE_W-1:0]      scale_q;
	logic                    en;
	logic                    skid_full_q;
	logic                    out_valid_q;
	lns_res_t                out_q;
	lns_res_t                skid_q;
	lns_res_t                res_c;

	logic [UNIFORM_BITS-1:0] r_c;
	logic                    pos_c;
	logic [UNIFORM_BITS-1:0] b_c;

	logic                    vld_s1, vld_s2, vld_s3, vld_s20, vld_s21, vld_s22;
	logic [UNIFORM_BITS-1:0] a_s1, a_s2;
	logic                    pos_s1, pos_s2, pos_s20, pos_s21, pos_s22;
	logic                    zero_s1, zero_s2, zero_s20, zero_s21, zero_s22;
	logic [K_W-1:0]          k_c, k_s2;
	lns_item_t               item_s3;
	logic [LOG_W-1:0]        t_s20, ln_s21, mag_s22;
	logic [LOG_W+MANT_W-1:0] ln_prod;
	logic [LOG_W+SCALE_W-1:0] mag_prod;

	logic                    sq_valid [SQ_STAGES+1];
	lns_item_t               sq_item  [SQ_STAGES+1];

	assign en            = !skid_full_q;
	assign uniform_ready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			scale_q <= noise_scale;
		end
	end

	// The log argument 1 - 2|u| scaled by the full-scale word is twice the
	// distance of the word from the nearer end of its range.
	always_comb begin
		r_c   = UNIFORM_BITS'(uniform_raw);
		pos_c = r_c[UNIFORM_BITS-1];
		b_c   = pos_c ? ~r_c : r_c;
	end

	always_comb begin
		k_c = '0;
		for (int i = 0; i < UNIFORM_BITS; i++) begin
			if (a_s1[i]) begin
				k_c = K_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
			vld_s22 <= 1'b0;
		end else if (en) begin
			vld_s1  <= uniform_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s20 <= sq_valid[SQ_STAGES];
			vld_s21 <= vld_s20;
			vld_s22 <= vld_s21;
		end
	end

	always_comb begin
		ln_prod  = (LOG_W+MANT_W)'(t_s20) * (LOG_W+MANT_W)'(LN2_Q32);
		mag_prod = (LOG_W+SCALE_W)'(ln_s21) * (LOG_W+SCALE_W)'(scale_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1          <= {b_c[UNIFORM_BITS-2:0], 1'b0};
			pos_s1        <= pos_c;
			zero_s1       <= (b_c[UNIFORM_BITS-2:0] == '0);
			a_s2          <= a_s1;
			k_s2          <= k_c;
			pos_s2        <= pos_s1;
			zero_s2       <= zero_s1;
			item_s3.positive <= pos_s2;
			item_s3.zero  <= zero_s2;
			item_s3.k     <= k_s2;
			item_s3.frac  <= '0;
			item_s3.mant  <= MANT_W'(a_s2) << (SHIFT_W'(MANT_W - 1) - SHIFT_W'(k_s2));
			t_s20         <= LOG2_MAX - {sq_item[SQ_STAGES].k, sq_item[SQ_STAGES].frac};
			pos_s20       <= sq_item[SQ_STAGES].positive;
			zero_s20      <= sq_item[SQ_STAGES].zero;
			ln_s21        <= ln_prod[LOG_W+MANT_W-1:MANT_W];
			pos_s21       <= pos_s20;
			zero_s21      <= zero_s20;
			mag_s22       <= mag_prod[LOG_W+SCALE_W-1:SCALE_W];
			pos_s22       <= pos_s21;
			zero_s22      <= zero_s21;
		end
	end

	assign sq_valid[0] = vld_s3;
	assign sq_item[0]  = item_s3;

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
		lns_sqr_stage u_sq (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (sq_valid[g]),
			.prev_item  (sq_item[g]),
			.next_valid (sq_valid[g+1]),
			.next_item  (sq_item[g+1])
		);
	end

	always_comb begin
		res_c.sat    = 1'b0;
		res_c.sample = '0;
		if (zero_s22) begin
			res_c.sat    = 1'b1;
			res_c.sample = pos_s22 ? POS_LIMIT : NEG_LIMIT;
		end else if (pos_s22) begin
			if (64'(mag_s22) > 64'(POS_LIMIT)) begin
				res_c.sat    = 1'b1;
				res_c.sample = POS_LIMIT;
			end else begin
				res_c.sample = OUT_W'(mag_s22);
			end
		end else begin
			if (64'(mag_s22) > 64'(NEG_LIMIT)) begin
				res_c.sat    = 1'b1;
				res_c.sample = NEG_LIMIT;
			end else begin
				res_c.sample = OUT_W'(0) - OUT_W'(mag_s22);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (en) begin
			if (vld_s22) begin
				if (!out_valid_q || noise_ready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_full_q <= 1'b1;
				end
			end else if (noise_ready) begin
				out_valid_q <= 1'b0;
			end
		end else if (noise_ready) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vld_s22) begin
				if (!out_valid_q || noise_ready) begin
					out_q <= res_c;
				end else begin
					skid_q <= res_c;
				end
			end
		end else if (noise_ready) begin
			out_q <= skid_q;
		end
	end

	assign noise_valid  = out_valid_q;
	assign noise_sample = out_q.sample;
	assign saturated    = out_q.sat;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid register full while output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !noise_ready |=> skid_full_q)
		else $error("skid register dropped a result during a stall");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && !noise_ready && vld_s22))
		else $error("skid register filled without a stalled result");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.sat |-> out_q.sample == POS_LIMIT || out_q.sample == NEG_LIMIT)
		else $error("saturated result is not at a range limit");

endmodule
